/* src/pfdc_pkg.sv */
// Shared widths, reset values and constants for the PWM frequency and duty capture block.
package pfdc_pkg;

    localparam int COUNTER_WIDTH_DEF = 16;
    localparam int RATE_W            = 24;
    localparam int DUTY_W            = 7;
    localparam int TICKS_W           = 16;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [RATE_W-1:0] TICK_RATE_RESET = 24'd1000000;
    localparam logic [DUTY_W-1:0] PERCENT_FULL    = 7'd100;

    typedef logic [RATE_W-1:0] t_rate;

endpackage

/* src/pfdc_chan_if.sv */
// Valid/ready channel interfaces for the level samples and the measurement results.
interface pfdc_in_if
    import pfdc_pkg::*;
;
    logic valid;
    logic ready;
    logic level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

interface pfdc_out_if
    import pfdc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [RATE_W-1:0]   frequency;
    logic [DUTY_W-1:0]   duty_percent;
    logic [TICKS_W-1:0]  period_ticks;
    logic [TICKS_W-1:0]  high_ticks;
    logic                zero_period;

    modport source (output valid, output frequency, output duty_percent,
                    output period_ticks, output high_ticks, output zero_period,
                    input ready);
    modport sink   (input valid, input frequency, input duty_percent,
                    input period_ticks, input high_ticks, input zero_period,
                    output ready);
endinterface

/* src/pfdc_front.sv */
// Edge detector, tick counter and capture registers that turn level samples into measurements.
module pfdc_front
    import pfdc_pkg::*;
#(
    parameter int CW = COUNTER_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pfdc_in_if.sink       i_in,
    input  logic          i_push_ready,
    output logic          o_push_valid,
    output logic [CW-1:0] o_push_period,
    output logic [CW-1:0] o_push_high
);

    localparam logic [1:0] PH_RISE_START = 2'd0;
    localparam logic [1:0] PH_FALL_HIGH  = 2'd1;
    localparam logic [1:0] PH_RISE_PER   = 2'd2;
    localparam logic [1:0] PH_FALL_END   = 2'd3;

    logic [1:0]    r_phase, n_phase;
    logic [CW-1:0] r_tick, n_tick;
    logic          r_last, n_last;
    logic [CW-1:0] r_high_cap, n_high_cap;
    logic [CW-1:0] r_period_cap, n_period_cap;
    logic [CW-1:0] tick_inc;
    logic          accept;
    logic          rising;
    logic          falling;
    logic          push;

    assign i_in.ready = i_push_ready;
    assign accept     = i_in.valid & i_push_ready;
    assign rising     = i_in.level & ~r_last;
    assign falling    = ~i_in.level & r_last;
    assign tick_inc   = r_tick + {{(CW-1){1'b0}}, 1'b1};

    always_comb begin
        n_phase      = r_phase;
        n_tick       = r_tick;
        n_last       = r_last;
        n_high_cap   = r_high_cap;
        n_period_cap = r_period_cap;
        push         = 1'b0;
        if (accept) begin
            n_tick = tick_inc;
            n_last = i_in.level;
            unique case (r_phase)
                PH_RISE_START: begin
                    if (rising) begin
                        n_tick  = '0;
                        n_phase = PH_FALL_HIGH;
                    end
                end
                PH_FALL_HIGH: begin
                    if (falling) begin
                        n_high_cap = tick_inc;
                        n_phase    = PH_RISE_PER;
                    end
                end
                PH_RISE_PER: begin
                    if (rising) begin
                        n_period_cap = tick_inc;
                        n_phase      = PH_FALL_END;
                    end
                end
                PH_FALL_END: begin
                    if (falling) begin
                        push    = 1'b1;
                        n_tick  = '0;
                        n_phase = PH_RISE_START;
                    end
                end
                default: begin
                    n_phase = PH_RISE_START;
                end
            endcase
        end
    end

    assign o_push_valid  = push;
    assign o_push_period = tick_inc - r_high_cap;
    assign o_push_high   = tick_inc - r_period_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_RISE_START;
            r_tick       <= '0;
            r_last       <= 1'b0;
            r_high_cap   <= '0;
            r_period_cap <= '0;
        end else begin
            r_phase      <= n_phase;
            r_tick       <= n_tick;
            r_last       <= n_last;
            r_high_cap   <= n_high_cap;
            r_period_cap <= n_period_cap;
        end
    end

endmodule

/* src/pfdc_queue.sv */
// Short first-in first-out queue of measurements between the capture front and the divider.
module pfdc_queue
    import pfdc_pkg::*;
#(
    parameter int W     = 2 * COUNTER_WIDTH_DEF,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push_valid,
    output logic         o_push_ready,
    input  logic [W-1:0] i_push_data,
    output logic         o_pop_valid,
    input  logic         i_pop_ready,
    output logic [W-1:0] o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign do_push      = i_push_valid & o_push_ready;
    assign do_pop       = o_pop_valid & i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* src/pfdc_back.sv */
// Bit-serial divider that turns a measurement into frequency and duty and holds the result.
module pfdc_back
    import pfdc_pkg::*;
#(
    parameter int CW = COUNTER_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_rate         i_tick_rate,
    input  logic          i_pop_valid,
    output logic          o_pop_ready,
    input  logic [CW-1:0] i_pop_period,
    input  logic [CW-1:0] i_pop_high,
    pfdc_out_if.source    o_out
);

    localparam int PW     = CW + DUTY_W;
    localparam int STEP_W = $clog2(RATE_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step;
    logic [CW-1:0]     r_period;
    logic [CW-1:0]     r_high;
    logic [PW-1:0]     r_prod;
    logic              r_sat;
    logic              r_zero;
    logic [CW-1:0]     r_fq_rem;
    logic [RATE_W-1:0] r_fq_num;
    logic [RATE_W-1:0] r_fq_quo;
    logic [CW-1:0]     r_dq_rem;
    logic [DUTY_W-1:0] r_dq_num;
    logic [DUTY_W-1:0] r_dq_quo;
    logic [RATE_W-1:0] r_freq;
    logic [DUTY_W-1:0] r_duty;
    logic [CW:0]       fq_sh;
    logic              fq_ge;
    logic [CW:0]       dq_sh;
    logic              dq_ge;
    logic [RATE_W-1:0] fq_quo_next;
    logic              last_step;

    assign o_pop_ready = (r_state == ST_IDLE);
    assign last_step   = (r_step == STEP_W'(RATE_W - 1));

    assign fq_sh       = {r_fq_rem, r_fq_num[RATE_W-1]};
    assign fq_ge       = (fq_sh >= {1'b0, r_period});
    assign dq_sh       = {r_dq_rem, r_dq_num[DUTY_W-1]};
    assign dq_ge       = (dq_sh >= {1'b0, r_period});
    assign fq_quo_next = {r_fq_quo[RATE_W-2:0], fq_ge};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_pop_valid) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (last_step) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (o_out.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_period <= i_pop_period;
                r_high   <= i_pop_high;
                r_prod   <= PW'(i_pop_high) * PW'(PERCENT_FULL);
            end
            ST_LOAD: begin
                r_step   <= '0;
                r_sat    <= (r_high >= r_period);
                r_zero   <= (r_period == '0);
                r_fq_rem <= '0;
                r_fq_num <= i_tick_rate;
                r_fq_quo <= '0;
                r_dq_rem <= r_prod[PW-1:DUTY_W];
                r_dq_num <= r_prod[DUTY_W-1:0];
                r_dq_quo <= '0;
            end
            ST_RUN: begin
                r_step   <= r_step + 1'b1;
                r_fq_rem <= fq_ge ? CW'(fq_sh - {1'b0, r_period}) : CW'(fq_sh);
                r_fq_num <= {r_fq_num[RATE_W-2:0], 1'b0};
                r_fq_quo <= fq_quo_next;
                if (r_step < STEP_W'(DUTY_W)) begin
                    r_dq_rem <= dq_ge ? CW'(dq_sh - {1'b0, r_period}) : CW'(dq_sh);
                    r_dq_num <= {r_dq_num[DUTY_W-2:0], 1'b0};
                    r_dq_quo <= {r_dq_quo[DUTY_W-2:0], dq_ge};
                end
                if (last_step) begin
                    r_freq <= r_zero ? '0 : fq_quo_next;
                    r_duty <= r_zero ? '0 : (r_sat ? PERCENT_FULL : r_dq_quo);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid        = (r_state == ST_DONE);
    assign o_out.frequency    = r_freq;
    assign o_out.duty_percent = r_duty;
    assign o_out.period_ticks = TICKS_W'(r_period);
    assign o_out.high_ticks   = TICKS_W'(r_high);
    assign o_out.zero_period  = r_zero;

endmodule

/* src/pwm_frequency_duty_capture.sv */
// Top level of the PWM frequency and duty capture block.
// One level sample is taken per clock while the input is valid and the queue has room. After a
// rising edge, a falling edge, a rising edge and a falling edge the block has one measurement of
// period and high time, which goes into a two-entry queue. A bit-serial divider takes each
// measurement from the queue, forms high times one hundred, loads its registers and runs 24
// division steps before the result stands in the output register; it then waits there until
// the transaction completes. The divider takes a new measurement only once the previous result
// has left the output register. The sample input stays ready while the queue has room, so it
// stalls only when measurements outpace the divider for longer than the queue can absorb. The
// tick rate register may be written only while no measurement is in flight.
module pwm_frequency_duty_capture
    import pfdc_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  t_rate       i_cfg_wdata,
    pfdc_in_if.sink     i_in,
    pfdc_out_if.source  o_out
);

    localparam int CW = COUNTER_WIDTH;

    t_rate           r_tick_rate;
    logic            push_valid;
    logic            push_ready;
    logic [CW-1:0]   push_period;
    logic [CW-1:0]   push_high;
    logic            pop_valid;
    logic            pop_ready;
    logic [2*CW-1:0] pop_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_rate <= TICK_RATE_RESET;
        end else if (i_cfg_we) begin
            r_tick_rate <= i_cfg_wdata;
        end
    end

    pfdc_front #(
        .CW (CW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_push_ready  (push_ready),
        .o_push_valid  (push_valid),
        .o_push_period (push_period),
        .o_push_high   (push_high)
    );

    pfdc_queue #(
        .W     (2 * CW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  ({push_period, push_high}),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    pfdc_back #(
        .CW (CW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick_rate  (r_tick_rate),
        .i_pop_valid  (pop_valid),
        .o_pop_ready  (pop_ready),
        .i_pop_period (pop_data[2*CW-1:CW]),
        .i_pop_high   (pop_data[CW-1:0]),
        .o_out        (o_out)
    );

endmodule

/* src/pfdc_checker.sv */
// Port-level checks on the result channel of the PWM frequency and duty capture block.
module pfdc_checker
    import pfdc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [RATE_W-1:0]  i_frequency,
    input logic [DUTY_W-1:0]  i_duty_percent,
    input logic [TICKS_W-1:0] i_period_ticks,
    input logic [TICKS_W-1:0] i_high_ticks,
    input logic               i_zero_period
);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before transaction");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_frequency) && $stable(i_duty_percent)
            && $stable(i_period_ticks) && $stable(i_high_ticks) && $stable(i_zero_period))
        else $error("result changed while stalled");

    a_zero_forces_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_zero_period |-> i_frequency == '0 && i_duty_percent == '0)
        else $error("zero period with non-zero frequency or duty");

    a_duty_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_duty_percent <= PERCENT_FULL)
        else $error("duty above full scale");

endmodule

bind pwm_frequency_duty_capture pfdc_checker u_pfdc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_frequency    (o_out.frequency),
    .i_duty_percent (o_out.duty_percent),
    .i_period_ticks (o_out.period_ticks),
    .i_high_ticks   (o_out.high_ticks),
    .i_zero_period  (o_out.zero_period)
);

/* tb/tb.sv */
// Self-checking testbench for the PWM frequency and duty capture block.
module tb;
    import pfdc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CNT_W       = COUNTER_WIDTH_DEF;
    localparam int SETTLE      = 40;
    localparam int HOLD_CYCLES = 400;

    typedef enum logic [1:0] {
        AWAIT_FIRST_RISE,
        AWAIT_HIGH_FALL,
        AWAIT_PERIOD_RISE,
        AWAIT_BOTH_FALL
    } t_capture_phase;

    typedef struct packed {
        t_rate              frequency;
        logic [DUTY_W-1:0]  duty_percent;
        logic [TICKS_W-1:0] period_ticks;
        logic [TICKS_W-1:0] high_ticks;
        logic               zero_period;
    } t_measurement;

    class capture_scoreboard;
        t_rate              tick_rate;
        t_capture_phase     phase;
        logic [CNT_W-1:0]   tick_count;
        logic               last_level;
        logic [CNT_W-1:0]   high_capture;
        logic [CNT_W-1:0]   period_capture;
        t_measurement       pending[$];
        int                 failures;
        int                 checked;

        function new();
            tick_rate      = TICK_RATE_RESET;
            phase          = AWAIT_FIRST_RISE;
            tick_count     = '0;
            last_level     = 1'b0;
            high_capture   = '0;
            period_capture = '0;
            failures       = 0;
            checked        = 0;
        endfunction

        function void set_rate(t_rate rate);
            tick_rate = rate;
        endfunction

        task report(string msg);
            failures++;
            $display("mismatch at %0t ns: %s", $time, msg);
        endtask

        function void note_sample(logic lvl);
            logic             rising;
            logic             falling;
            logic [CNT_W-1:0] span_period;
            logic [CNT_W-1:0] span_high;
            int unsigned      duty_wide;
            t_measurement     meas;
            rising     = lvl && !last_level;
            falling    = !lvl && last_level;
            tick_count = tick_count + 1'b1;
            last_level = lvl;
            case (phase)
                AWAIT_FIRST_RISE: if (rising) begin
                    tick_count = '0;
                    phase      = AWAIT_HIGH_FALL;
                end
                AWAIT_HIGH_FALL: if (falling) begin
                    high_capture = tick_count;
                    phase        = AWAIT_PERIOD_RISE;
                end
                AWAIT_PERIOD_RISE: if (rising) begin
                    period_capture = tick_count;
                    phase          = AWAIT_BOTH_FALL;
                end
                default: if (falling) begin
                    span_period       = tick_count - high_capture;
                    span_high         = tick_count - period_capture;
                    meas              = '0;
                    meas.period_ticks = span_period[TICKS_W-1:0];
                    meas.high_ticks   = span_high[TICKS_W-1:0];
                    if (span_period == '0) begin
                        meas.zero_period = 1'b1;
                    end else begin
                        meas.frequency = t_rate'(tick_rate / span_period);
                        duty_wide = (32'(span_high) * 32'(PERCENT_FULL)) / 32'(span_period);
                        if (duty_wide > 32'(PERCENT_FULL))
                            duty_wide = 32'(PERCENT_FULL);
                        meas.duty_percent = duty_wide[DUTY_W-1:0];
                    end
                    pending.push_back(meas);
                    tick_count = '0;
                    phase      = AWAIT_FIRST_RISE;
                end
            endcase
        endfunction

        task check_result(t_measurement got);
            t_measurement want;
            if (pending.size() == 0) begin
                report("result arrived with none expected");
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.frequency !== want.frequency)
                report($sformatf("frequency expected %0d, got %0d",
                                 want.frequency, got.frequency));
            if (got.duty_percent !== want.duty_percent)
                report($sformatf("duty_percent expected %0d, got %0d",
                                 want.duty_percent, got.duty_percent));
            if (got.period_ticks !== want.period_ticks)
                report($sformatf("period_ticks expected %0d, got %0d",
                                 want.period_ticks, got.period_ticks));
            if (got.high_ticks !== want.high_ticks)
                report($sformatf("high_ticks expected %0d, got %0d",
                                 want.high_ticks, got.high_ticks));
            if (got.zero_period !== want.zero_period)
                report($sformatf("zero_period expected %0b, got %0b",
                                 want.zero_period, got.zero_period));
        endtask
    endclass

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  cfg_we;
    t_rate cfg_wdata;
    bit    src_gapless = 1'b0;
    bit    sink_gapless = 1'b0;
    bit    hold_request = 1'b0;
    int    samples_sent = 0;
    int    rate_writes = 0;

    capture_scoreboard sb = new();

    pfdc_in_if  in_ch ();
    pfdc_out_if out_ch ();

    pwm_frequency_duty_capture #(
        .COUNTER_WIDTH (CNT_W)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        t_measurement got;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got.frequency    = out_ch.frequency;
            got.duty_percent = out_ch.duty_percent;
            got.period_ticks = out_ch.period_ticks;
            got.high_ticks   = out_ch.high_ticks;
            got.zero_period  = out_ch.zero_period;
            sb.check_result(got);
        end
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.note_sample(in_ch.level);
    end

    initial begin
        int gap;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = sink_gapless ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
        end
    end

    initial begin
        #60_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task send_level(logic lvl);
        int gap;
        gap = src_gapless ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.level <= lvl;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        samples_sent++;
    endtask

    task send_run(logic lvl, int count);
        repeat (count) send_level(lvl);
    endtask

    task send_measurement(int high1, int low1, int high2, int low2);
        send_run(1'b1, high1);
        send_run(1'b0, low1);
        send_run(1'b1, high2);
        send_run(1'b0, low2);
    endtask

    function int draw_run_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            return $urandom_range(1, 6);
        else if (pick < 97)
            return $urandom_range(7, 30);
        return $urandom_range(31, 120);
    endfunction

    task wait_for_drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task write_tick_rate(t_rate rate);
        wait_for_drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= rate;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_rate(rate);
        rate_writes++;
    endtask

    task random_phase(int quota, bit with_pressure);
        int start;
        int pick;
        start = samples_sent;
        while (samples_sent - start < quota) begin
            pick = $urandom_range(0, 99);
            if (with_pressure) begin
                hold_request = 1'b1;
                src_gapless  = 1'b1;
                repeat (30) begin
                    send_level(1'b1);
                    send_level(1'b0);
                end
                src_gapless = 1'b0;
                with_pressure = 1'b0;
            end else if (pick < 75) begin
                send_measurement(draw_run_length(), draw_run_length(),
                                 draw_run_length(), draw_run_length());
            end else if (pick < 85) begin
                send_run(1'b1, draw_run_length());
                send_run(1'b0, draw_run_length());
                send_run(1'b1, draw_run_length());
            end else begin
                repeat ($urandom_range(1, 12)) send_level(1'(($urandom() >> 7) & 1));
            end
        end
    endtask

    initial begin
        in_ch.valid <= 1'b0;
        in_ch.level <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_level(1'b1);
        send_run(1'b1, 2);
        send_run(1'b0, 3);
        send_run(1'b1, 4);
        send_run(1'b0, 1);
        send_measurement(1, 1, 1, 1);
        send_run(1'b0, 2);
        send_measurement(3, 1, 2, 2);

        write_tick_rate(24'd1000000);
        src_gapless  = 1'b1;
        sink_gapless = 1'b1;
        send_measurement(1, 1, 1, 1);
        send_measurement(2, 1, 1, 2);
        send_measurement(1, 3, 4, 1);
        send_measurement(6, 2, 1, 1);
        src_gapless  = 1'b0;
        sink_gapless = 1'b0;

        write_tick_rate(24'hFFFFFF);
        send_measurement(1, 1, 1, 1);
        send_measurement(5, 3, 2, 1);
        write_tick_rate(24'd1);
        send_measurement(2, 3, 2, 1);
        write_tick_rate(24'd0);
        send_measurement(1, 2, 3, 1);

        write_tick_rate(24'hFFFFFF);
        random_phase(250, 1'b0);
        write_tick_rate(24'd1);
        src_gapless = 1'b1;
        random_phase(200, 1'b0);
        src_gapless = 1'b0;
        write_tick_rate(t_rate'($urandom_range(1, 24'hFFFFFF)));
        sink_gapless = 1'b1;
        random_phase(250, 1'b1);
        sink_gapless = 1'b0;
        write_tick_rate(t_rate'($urandom_range(1, 5000)));
        random_phase(250, 1'b0);
        write_tick_rate(TICK_RATE_RESET);
        random_phase(250, 1'b1);

        wait_for_drain();
        if (sb.pending.size() != 0)
            sb.report("measurements still outstanding at the end");
        $display("Sent %0d level samples and checked %0d measurements across %0d tick rates,",
                 samples_sent, sb.checked, rate_writes);
        $display("covering short and long pulses, extreme tick rates and a long output stall.");
        if (sb.failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
